### rtl/bsr_pkg.sv
// Shared types, constants and fixed-point helpers for the Bakhshali square root.
// No dependencies.
package bsr_pkg;

    localparam int TOTAL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DIVD_BITS  = TOTAL_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(DIVD_BITS);

    typedef logic signed [TOTAL_BITS-1:0] t_fx;

    typedef enum logic [1:0] {
        CFG_START_GUESS = 2'd0,
        CFG_STOP_TOL    = 2'd1,
        CFG_ITER_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_DIV1,
        ST_BSTEP,
        ST_DIV2,
        ST_DONE
    } t_state;

    // Divider request: magnitudes plus sign of the result.
    typedef struct packed {
        logic                  start;
        logic [DIVD_BITS-1:0]  dividend;
        logic [TOTAL_BITS-1:0] divisor;
        logic                  neg;
    } t_div_req;

    localparam logic signed [TOTAL_BITS:0] FX_MAX = (17'sd1 <<< (TOTAL_BITS-1)) - 17'sd1;
    localparam logic signed [TOTAL_BITS:0] FX_MIN = -(17'sd1 <<< (TOTAL_BITS-1));

    // Saturate a sum that grew by one bit.
    function automatic t_fx sat17(input logic signed [TOTAL_BITS:0] v);
        t_fx r;
        if (v > FX_MAX)      r = FX_MAX[TOTAL_BITS-1:0];
        else if (v < FX_MIN) r = FX_MIN[TOTAL_BITS-1:0];
        else                 r = v[TOTAL_BITS-1:0];
        return r;
    endfunction

    // Fixed-point product, truncated toward zero, saturated.
    function automatic t_fx fx_mul(input t_fx p, input t_fx q);
        logic signed [2*TOTAL_BITS-1:0] pr;
        logic signed [2*TOTAL_BITS-1:0] adj;
        logic signed [2*TOTAL_BITS-1:0] sh;
        t_fx r;
        pr  = p * q;
        adj = pr[2*TOTAL_BITS-1] ? pr + ((2*TOTAL_BITS)'(1) <<< FRAC_BITS) - 1 : pr;
        sh  = adj >>> FRAC_BITS;
        if (sh > 32'(FX_MAX))      r = FX_MAX[TOTAL_BITS-1:0];
        else if (sh < 32'(FX_MIN)) r = FX_MIN[TOTAL_BITS-1:0];
        else                       r = sh[TOTAL_BITS-1:0];
        return r;
    endfunction

    function automatic logic [TOTAL_BITS-1:0] fx_abs(input t_fx v);
        return v[TOTAL_BITS-1] ? TOTAL_BITS'(-v) : TOTAL_BITS'(v);
    endfunction

endpackage

### rtl/bakhshali_square_root.sv
// Bakhshali square root: Q8.8 radicand in, root estimate and status out.
// Each iteration runs check, multiply, two serial divisions on one shared divider and the
// b step; the limit or a zero guess ends the run at a check, and a zero 2b ends it in the
// b step.
// Throughput: one word at a time; not ready until the result word is taken.
// Reset (synchronous, active low): idle, start_guess 1.0, tolerance 1 LSB,
// iteration limit 1000.
module bakhshali_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [14:0] radicand, [15] zero
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [15:0] root, [25:16] steps_done,
                                          // [26] converged, [27] divide_fault
);
    import bsr_pkg::*;

    // config registers
    logic [14:0] r_start, r_tol;
    logic [9:0]  r_limit;

    // working state for one radicand
    t_state r_state, n_state;
    t_fx    r_s, r_x, r_a, r_b;
    logic [9:0] r_it;
    logic   r_conv, r_fault;

    // shared multiplier: x*x in MUL1, a*a in BSTEP
    t_fx    w_mop, w_prod;
    t_fx    w_t, w_d1, w_bn, w_d2, w_xn;
    logic [TOTAL_BITS-1:0] w_amag;

    t_div_req w_req;
    logic     w_ddone;
    t_fx      w_quo;

    bsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    assign w_mop  = (r_state == ST_BSTEP) ? r_a : r_x;
    assign w_prod = fx_mul(w_mop, w_mop);
    assign w_t    = sat17($signed({r_s[TOTAL_BITS-1], r_s}) - $signed({w_prod[TOTAL_BITS-1], w_prod}));
    assign w_d1   = sat17($signed({r_x, 1'b0}));
    assign w_bn   = sat17($signed({r_x[TOTAL_BITS-1], r_x}) + $signed({r_a[TOTAL_BITS-1], r_a}));
    assign w_d2   = sat17($signed({w_bn, 1'b0}));
    assign w_xn   = sat17($signed({r_b[TOTAL_BITS-1], r_b}) - $signed({w_quo[TOTAL_BITS-1], w_quo}));
    assign w_amag = fx_abs(r_a);

    // divider requests
    always_comb begin
        w_req = '0;
        if (r_state == ST_MUL1) begin
            w_req.start    = 1'b1;
            w_req.dividend = {fx_abs(w_t), FRAC_BITS'(0)};
            w_req.divisor  = fx_abs(w_d1);
            w_req.neg      = w_t[TOTAL_BITS-1] ^ w_d1[TOTAL_BITS-1];
        end else if (r_state == ST_BSTEP && w_bn != '0) begin
            w_req.start    = 1'b1;
            w_req.dividend = {fx_abs(w_prod), FRAC_BITS'(0)};
            w_req.divisor  = fx_abs(w_d2);
            w_req.neg      = w_prod[TOTAL_BITS-1] ^ w_d2[TOTAL_BITS-1];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_it >= r_limit || r_x == '0) n_state = ST_DONE;
                else                              n_state = ST_MUL1;
            end
            ST_MUL1:  n_state = ST_DIV1;
            ST_DIV1:  if (w_ddone) n_state = ST_BSTEP;
            ST_BSTEP: n_state = (w_bn == '0) ? ST_DONE : ST_DIV2;
            ST_DIV2: begin
                if (w_ddone) begin
                    // tolerance test on |a|; a pass ends the run uncounted
                    if ({1'b0, w_amag} < {2'b0, r_tol}) n_state = ST_DONE;
                    else                                n_state = ST_CHECK;
                end
            end
            ST_DONE:  if (i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // port outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_DONE: o_m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign o_m_axis_tdata = {4'b0, r_fault, r_conv, r_it, r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 15'd256;
            r_tol   <= 15'd1;
            r_limit <= 10'd1000;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_START_GUESS: r_start <= i_cfg_data;
                    CFG_STOP_TOL:    r_tol   <= i_cfg_data;
                    CFG_ITER_LIMIT:  r_limit <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end

        case (r_state)
            ST_IDLE: begin
                r_s     <= {1'b0, i_s_axis_tdata[14:0]};
                r_x     <= {1'b0, r_start};
                r_it    <= '0;
                r_conv  <= 1'b0;
                r_fault <= 1'b0;
            end
            ST_CHECK: if (r_it < r_limit && r_x == '0) r_fault <= 1'b1;
            ST_DIV1:  if (w_ddone) r_a <= w_quo;
            ST_BSTEP: begin
                r_b <= w_bn;
                if (w_bn == '0) r_fault <= 1'b1;
            end
            ST_DIV2: begin
                if (w_ddone) begin
                    r_x <= w_xn;
                    if ({1'b0, w_amag} < {2'b0, r_tol}) r_conv <= 1'b1;
                    else                                r_it   <= r_it + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/bsr_div.sv
// Restoring divider, one quotient bit per cycle, signed saturated result.
// Depends on bsr_pkg.
module bsr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsr_pkg::t_div_req i_req,
    output logic              o_done,
    output bsr_pkg::t_fx      o_quo
);
    import bsr_pkg::*;

    logic [TOTAL_BITS-1:0] r_rem, n_rem;
    logic [DIVD_BITS-1:0]  r_quo, n_quo;
    logic [TOTAL_BITS-1:0] r_div;
    logic                  r_neg;
    logic                  r_busy, n_busy;
    logic                  r_fin, n_fin;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [TOTAL_BITS:0]   w_sh;
    logic                  w_ge;
    logic signed [DIVD_BITS:0] w_sq;

    assign w_sh = {r_rem, r_quo[DIVD_BITS-1]};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? TOTAL_BITS'(w_sh - {1'b0, r_div}) : w_sh[TOTAL_BITS-1:0];
            n_quo = {r_quo[DIVD_BITS-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(DIVD_BITS-1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end
    end

    // apply sign, then clamp to the fixed-point range
    always_comb begin
        w_sq = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (w_sq > (DIVD_BITS+1)'(FX_MAX))      o_quo = FX_MAX[TOTAL_BITS-1:0];
        else if (w_sq < (DIVD_BITS+1)'(FX_MIN)) o_quo = FX_MIN[TOTAL_BITS-1:0];
        else                                    o_quo = w_sq[TOTAL_BITS-1:0];
    end

    assign o_done = r_fin;

endmodule
